// ----- sv/pcef_pkg.sv -----
// Shared types and constants of the phase-current EMA filter.
package pcef_pkg;

  // Fixed field widths
  localparam int ADC_BITS      = 12;
  localparam int FRACTION_BITS = 16;
  localparam int ACC_BITS      = ADC_BITS + FRACTION_BITS;
  localparam int CUR_BITS      = ACC_BITS + 1;
  localparam int PROD_BITS     = ACC_BITS + 16;

  // Configuration registers
  localparam int SPV_W     = 7;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPS_PER_DIGIT    = 1'b1;

  localparam logic [SPV_W-1:0]  SPV_RESET  = 7'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1218;

  // Request codes on the input stream
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_CALIB   = 2'd1;
  localparam logic [1:0] REQ_REFLECT = 2'd2;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 88;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CALIB,
    OP_REFLECT
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADC_BITS-1:0] sample;
  } op_item_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- sv/pcef_front.sv -----
// Front end: accepts request beats, classifies them and drops unused codes.
module pcef_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [1:0]                        req_type,
  input  logic [pcef_pkg::ADC_BITS-1:0]     adc_sample,
  output logic                              q_valid,
  input  logic                              q_ready,
  output pcef_pkg::op_item_t                q_item
);

  logic               hold_valid;
  pcef_pkg::op_item_t hold_item;
  pcef_pkg::op_item_t item_next;
  logic               keep;

  // Classify the incoming request
  always_comb begin
    item_next.sample = adc_sample;
    item_next.kind   = pcef_pkg::OP_SAMPLE;
    keep             = 1'b1;
    case (req_type)
      pcef_pkg::REQ_SAMPLE:  item_next.kind = pcef_pkg::OP_SAMPLE;
      pcef_pkg::REQ_CALIB:   item_next.kind = pcef_pkg::OP_CALIB;
      pcef_pkg::REQ_REFLECT: item_next.kind = pcef_pkg::OP_REFLECT;
      default:               keep = 1'b0;
    endcase
  end

  assign s_tready = !hold_valid || q_ready;
  assign q_valid  = hold_valid;
  assign q_item   = hold_item;

  // Hold one classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= keep;
    end else if (q_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_item <= item_next;
    end
  end

endmodule

// ----- sv/pcef_queue.sv -----
// Short queue of classified requests between front and back.
module pcef_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcef_pkg::op_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output pcef_pkg::op_item_t out_item
);

  localparam int PTR_W = (pcef_pkg::QUEUE_DEPTH > 1) ? $clog2(pcef_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pcef_pkg::QUEUE_DEPTH + 1);

  pcef_pkg::op_item_t entry [pcef_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(pcef_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pcef_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pcef_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- sv/pcef_back.sv -----
// Back end: filter state, offset, sample counter and configuration registers.
module pcef_back #(
  parameter int FILTER_SHIFT = 4,
  parameter int MAX_SAMPLES  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcef_pkg::cfg_wr_t                   cfg,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  pcef_pkg::op_item_t                  q_item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [pcef_pkg::ACC_BITS-1:0]       res_avg,
  output logic [pcef_pkg::ACC_BITS-1:0]       res_off,
  output logic [pcef_pkg::GAIN_W-1:0]         gain
);

  localparam int ACC_W = pcef_pkg::ACC_BITS;
  localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES + 1) : 1;
  localparam int CMP_W = (CNT_W > pcef_pkg::SPV_W) ? CNT_W : pcef_pkg::SPV_W;

  logic [ACC_W-1:0]          avg;
  logic [ACC_W-1:0]          off;
  logic [CNT_W-1:0]          cnt;
  logic [pcef_pkg::SPV_W-1:0] spv;

  logic [ACC_W-1:0] avg_next;
  logic [ACC_W-1:0] decay;
  logic [ACC_W-1:0] step;
  logic [ACC_W:0]   sum;
  logic [ACC_W:0]   twice;
  logic [ACC_W:0]   refl;
  logic [CMP_W-1:0] eff;
  logic [CMP_W-1:0] cnt_next;
  logic             pop;
  logic             emit;

  assign q_ready = !res_valid || res_ready;
  assign pop     = q_valid && q_ready;

  // Effective count: zero acts as one, large values clip at the maximum
  always_comb begin
    eff = CMP_W'(spv);
    if (CMP_W'(spv) > CMP_W'(MAX_SAMPLES)) begin
      eff = CMP_W'(MAX_SAMPLES);
    end
    if (spv == '0) begin
      eff = CMP_W'(1);
    end
  end

  // Filter update and reflection arithmetic
  always_comb begin
    decay = avg - (avg >> FILTER_SHIFT);
    step  = ACC_W'({q_item.sample, {pcef_pkg::FRACTION_BITS{1'b0}}} >> FILTER_SHIFT);
    sum   = {1'b0, decay} + {1'b0, step};
    twice = {off, 1'b0};
    refl  = twice - {1'b0, avg};
    avg_next = avg;
    case (q_item.kind)
      pcef_pkg::OP_SAMPLE: begin
        avg_next = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
      end
      pcef_pkg::OP_REFLECT: begin
        if (twice <= {1'b0, avg}) begin
          avg_next = '0;
        end else begin
          avg_next = refl[ACC_W] ? {ACC_W{1'b1}} : refl[ACC_W-1:0];
        end
      end
      default: avg_next = avg;
    endcase
    cnt_next = CMP_W'(cnt) + 1'b1;
    emit     = (q_item.kind == pcef_pkg::OP_SAMPLE) && (cnt_next >= eff);
  end

  // Update state on each popped request; configuration writes come in idle by rule of the user, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      avg  <= '0;
      off  <= '0;
      cnt  <= '0;
      spv  <= pcef_pkg::SPV_RESET;
      gain <= pcef_pkg::GAIN_RESET;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          pcef_pkg::REG_SAMPLES_PER_VALUE: begin
            spv <= cfg.data[pcef_pkg::SPV_W-1:0];
            cnt <= '0;
          end
          pcef_pkg::REG_AMPS_PER_DIGIT: gain <= cfg.data[pcef_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        avg <= avg_next;
        if (q_item.kind == pcef_pkg::OP_CALIB) begin
          off <= avg;
        end
        if (q_item.kind == pcef_pkg::OP_SAMPLE) begin
          cnt <= emit ? '0 : cnt_next[CNT_W-1:0];
        end
      end
    end
  end

  // Hand a snapshot to the result pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_ready) begin
      res_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_avg <= avg_next;
      res_off <= off;
    end
  end

endmodule

// ----- sv/pcef_result.sv -----
// Result pipeline: difference, gain multiply, sign and output register.
module pcef_result (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcef_pkg::ACC_BITS-1:0]   in_avg,
  input  logic [pcef_pkg::ACC_BITS-1:0]   in_off,
  input  logic [pcef_pkg::GAIN_W-1:0]     gain,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcef_pkg::ACC_BITS-1:0]   out_avg,
  output logic [pcef_pkg::ACC_BITS-1:0]   out_off,
  output logic [pcef_pkg::CUR_BITS-1:0]   out_cur
);

  localparam int ACC_W  = pcef_pkg::ACC_BITS;
  localparam int PROD_W = pcef_pkg::PROD_BITS;

  // Stage one: magnitude and sign of offset minus average
  logic             s1_valid;
  logic             s1_ready;
  logic [ACC_W-1:0] s1_avg;
  logic [ACC_W-1:0] s1_off;
  logic [ACC_W-1:0] s1_mag;
  logic             s1_neg;

  // Stage two: scaled magnitude
  logic             s2_valid;
  logic             s2_ready;
  logic [ACC_W-1:0] s2_avg;
  logic [ACC_W-1:0] s2_off;
  logic [ACC_W-1:0] s2_mag;
  logic             s2_neg;

  logic             neg_in;
  logic [ACC_W-1:0] mag_in;
  logic [PROD_W-1:0] prod;
  logic [pcef_pkg::CUR_BITS-1:0] cur_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s2_valid || s2_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_comb begin
    neg_in   = in_off < in_avg;
    mag_in   = neg_in ? (in_avg - in_off) : (in_off - in_avg);
    prod     = PROD_W'(s1_mag) * PROD_W'(gain);
    cur_next = s2_neg ? (-{1'b0, s2_mag}) : {1'b0, s2_mag};
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Move payload along the stages
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_avg <= in_avg;
      s1_off <= in_off;
      s1_mag <= mag_in;
      s1_neg <= neg_in;
    end
    if (s1_ready && s1_valid) begin
      s2_avg <= s1_avg;
      s2_off <= s1_off;
      s2_mag <= prod[PROD_W-1:pcef_pkg::FRACTION_BITS];
      s2_neg <= s1_neg;
    end
    if (s2_ready && s2_valid) begin
      out_avg <= s2_avg;
      out_off <= s2_off;
      out_cur <= cur_next;
    end
  end

endmodule

// ----- sv/phase_current_ema_filter_unit.sv -----
// Top level of the phase-current EMA filter with offset calibration.
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------
//  s_*       | in        | tuser req_type, tdata adc_sample
//  m_*       | out       | tdata average_out, offset_out, current_out
//  cfg_*     | in        | register write, index 0 samples, 1 gain
//
// One request beat is taken every cycle while s_tready is high; the filter state
// updates in the back end, so requests flow back to back.
// m_tvalid rises once the sample completing a count has passed the registers
// front, queue, state update, difference, multiply and output register.
// Reset is synchronous and clears all valid flags, the state and the registers.
// A stalled m_tready fills the result stages, then the queue, then drops s_tready.
module phase_current_ema_filter_unit #(
  parameter int FILTER_SHIFT = 4,
  parameter int MAX_SAMPLES  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bits 11:0 adc_sample
  input  logic [pcef_pkg::S_TDATA_W-1:0]    s_tdata,
  // bits 1:0 req_type
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bits 27:0 average_out, 55:28 offset_out, 84:56 current_out
  output logic [pcef_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [pcef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcef_pkg::CFG_DAT_W-1:0]    cfg_data
);

  pcef_pkg::op_item_t f_item;
  pcef_pkg::op_item_t q_item;
  pcef_pkg::cfg_wr_t  cfg;
  logic               f_valid;
  logic               f_ready;
  logic               q_valid;
  logic               q_ready;
  logic               r_valid;
  logic               r_ready;
  logic [pcef_pkg::ACC_BITS-1:0] r_avg;
  logic [pcef_pkg::ACC_BITS-1:0] r_off;
  logic [pcef_pkg::GAIN_W-1:0]   gain;
  logic [pcef_pkg::ACC_BITS-1:0] o_avg;
  logic [pcef_pkg::ACC_BITS-1:0] o_off;
  logic [pcef_pkg::CUR_BITS-1:0] o_cur;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  pcef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .req_type   (s_tuser),
    .adc_sample (s_tdata[pcef_pkg::ADC_BITS-1:0]),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_item     (f_item)
  );

  pcef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  pcef_back #(
    .FILTER_SHIFT (FILTER_SHIFT),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (r_valid),
    .res_ready (r_ready),
    .res_avg   (r_avg),
    .res_off   (r_off),
    .gain      (gain)
  );

  pcef_result u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_avg    (r_avg),
    .in_off    (r_off),
    .gain      (gain),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_avg   (o_avg),
    .out_off   (o_off),
    .out_cur   (o_cur)
  );

  // Pack the result beat, zero padding to whole bytes
  assign m_tdata = {
    {(pcef_pkg::M_TDATA_W - pcef_pkg::CUR_BITS - 2 * pcef_pkg::ACC_BITS){1'b0}},
    o_cur, o_off, o_avg
  };

endmodule

// ----- sv/pcef_checker.sv -----
// Port-level checker for the phase-current EMA filter, bound to the top level.
module pcef_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pcef_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [pcef_pkg::ACC_BITS-1:0] avg_f;
  logic [pcef_pkg::ACC_BITS-1:0] off_f;
  logic [pcef_pkg::CUR_BITS-1:0] cur_f;

  assign avg_f = m_tdata[pcef_pkg::ACC_BITS-1:0];
  assign off_f = m_tdata[2*pcef_pkg::ACC_BITS-1:pcef_pkg::ACC_BITS];
  assign cur_f = m_tdata[2*pcef_pkg::ACC_BITS+pcef_pkg::CUR_BITS-1:2*pcef_pkg::ACC_BITS];

  // A stalled result beat holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // No result beat straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A negative current needs an average above the offset
  a_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cur_f[pcef_pkg::CUR_BITS-1] |-> off_f < avg_f)
    else $error("current sign disagrees with offset and average");

  // Equal offset and average give zero current
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (off_f == avg_f) |-> (cur_f == '0))
    else $error("nonzero current with offset equal to average");

  // The current never reaches the most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cur_f != {1'b1, {(pcef_pkg::CUR_BITS-1){1'b0}}})
    else $error("current outside its range");

endmodule

bind phase_current_ema_filter_unit pcef_checker u_pcef_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the phase-current EMA filter unit.
`timescale 1ns / 100ps

module tb;

  localparam int FILTER_SHIFT = 4;
  localparam int MAX_SAMPLES  = 64;
  localparam int ADC_MAX      = (1 << pcef_pkg::ADC_BITS) - 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 20;
  localparam int LONG_HOLD    = 300;

  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [63:0] ACC_MAX       = (64'd1 << pcef_pkg::ACC_BITS) - 64'd1;
  localparam logic [63:0] CURRENT_LIMIT = 64'd268435455;

  typedef logic [pcef_pkg::ADC_BITS-1:0]  adc_word_t;
  typedef logic [pcef_pkg::S_TDATA_W-1:0] s_word_t;
  typedef logic [pcef_pkg::CFG_DAT_W-1:0] cfg_word_t;
  typedef logic [pcef_pkg::GAIN_W-1:0]    gain_word_t;

  typedef struct packed {
    logic [1:0] code;
    adc_word_t  adc;
  } adc_req_t;

  typedef struct packed {
    logic [pcef_pkg::ACC_BITS-1:0]        average;
    logic [pcef_pkg::ACC_BITS-1:0]        offset;
    logic signed [pcef_pkg::CUR_BITS-1:0] current;
  } ema_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // bits 11:0 adc_sample
  logic [pcef_pkg::S_TDATA_W-1:0] s_tdata = '0;
  // bits 1:0 req_type
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // bits 27:0 average_out, 55:28 offset_out, 84:56 current_out
  logic [pcef_pkg::M_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [pcef_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcef_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  phase_current_ema_filter_unit #(
    .FILTER_SHIFT(FILTER_SHIFT),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, results waiting for the output
  adc_req_t    req_feed[$];
  ema_result_t results_due[$];

  // Filter state as the design should hold it
  logic [pcef_pkg::ACC_BITS-1:0] ema_average = '0;
  logic [pcef_pkg::ACC_BITS-1:0] ema_offset  = '0;
  logic [pcef_pkg::SPV_W-1:0]    spv_reg     = pcef_pkg::SPV_RESET;
  logic [pcef_pkg::GAIN_W-1:0]   gain_reg    = pcef_pkg::GAIN_RESET;
  int                            samples_seen = 0;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_calib = 0;
  int n_reflect = 0;
  int n_clamp_top = 0;
  int n_clamp_zero = 0;
  int n_ignored = 0;
  int n_settings = 0;

  bit hold_req = 1'b0;

  // Work out the effect of one accepted request and queue any result
  task automatic ema_step(logic [1:0] code, adc_word_t adc);
    logic [63:0] acc;
    logic [63:0] twice;
    logic [63:0] mag;
    logic        neg;
    int          count_target;
    ema_result_t r;
    case (code)
      pcef_pkg::REQ_CALIB: begin
        ema_offset = ema_average;
        n_calib++;
      end
      pcef_pkg::REQ_REFLECT: begin
        n_reflect++;
        twice = 64'(ema_offset) << 1;
        if (twice <= 64'(ema_average)) begin
          ema_average = '0;
          n_clamp_zero++;
        end else begin
          acc = twice - 64'(ema_average);
          if (acc > ACC_MAX) begin
            acc = ACC_MAX;
            n_clamp_top++;
          end
          ema_average = acc[pcef_pkg::ACC_BITS-1:0];
        end
      end
      pcef_pkg::REQ_SAMPLE: begin
        acc = 64'(ema_average) - (64'(ema_average) >> FILTER_SHIFT)
            + ((64'(adc) << pcef_pkg::FRACTION_BITS) >> FILTER_SHIFT);
        if (acc > ACC_MAX) acc = ACC_MAX;
        ema_average = acc[pcef_pkg::ACC_BITS-1:0];
        count_target = (spv_reg > MAX_SAMPLES) ? MAX_SAMPLES : int'(spv_reg);
        if (count_target == 0) count_target = 1;
        samples_seen++;
        if (samples_seen >= count_target) begin
          samples_seen = 0;
          neg = ema_offset < ema_average;
          mag = neg ? 64'(ema_average - ema_offset) : 64'(ema_offset - ema_average);
          mag = (mag * 64'(gain_reg)) >> pcef_pkg::FRACTION_BITS;
          if (mag > CURRENT_LIMIT) mag = CURRENT_LIMIT;
          r.average = ema_average;
          r.offset  = ema_offset;
          r.current = neg ? -mag[pcef_pkg::CUR_BITS-1:0] : mag[pcef_pkg::CUR_BITS-1:0];
          results_due.push_back(r);
        end
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic note_error(string what);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] ERROR: %s", $time, what);
  endtask

  // Track register writes and accepted beats, check result beats
  always @(posedge clk) begin
    ema_result_t exp_r;
    ema_result_t got_r;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          pcef_pkg::REG_SAMPLES_PER_VALUE: begin
            spv_reg = cfg_data[pcef_pkg::SPV_W-1:0];
            samples_seen = 0;
          end
          pcef_pkg::REG_AMPS_PER_DIGIT: gain_reg = cfg_data[pcef_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        n_accepted++;
        ema_step(s_tuser, s_tdata[pcef_pkg::ADC_BITS-1:0]);
      end
      if (m_tvalid && m_tready) begin
        got_r.average = m_tdata[pcef_pkg::ACC_BITS-1:0];
        got_r.offset  = m_tdata[2*pcef_pkg::ACC_BITS-1:pcef_pkg::ACC_BITS];
        got_r.current = m_tdata[2*pcef_pkg::ACC_BITS+pcef_pkg::CUR_BITS-1:
                                2*pcef_pkg::ACC_BITS];
        if (results_due.size() == 0) begin
          note_error($sformatf("result beat with none due: avg %h off %h cur %h",
                               got_r.average, got_r.offset, got_r.current));
        end else begin
          exp_r = results_due.pop_front();
          n_checked++;
          if (got_r.average !== exp_r.average || got_r.offset !== exp_r.offset ||
              got_r.current !== exp_r.current)
            note_error($sformatf({"result %0d: avg exp %h got %h, off exp %h got %h, ",
                                  "cur exp %0d got %0d"}, n_checked,
                                 exp_r.average, got_r.average, exp_r.offset, got_r.offset,
                                 exp_r.current, got_r.current));
        end
      end
    end
  end

  // Driver: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    adc_req_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || req_feed.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        beat = req_feed.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= beat.code;
        s_tdata  <= s_word_t'(beat.adc);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            7:       gap_left = $urandom_range(10, 25);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // Receiver: stall pattern of its own plus the occasional long hold-off
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(10, 60);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= (rx_tick % 4 == 0);
          default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic queue_req(logic [1:0] code, adc_word_t adc);
    adc_req_t r;
    r.code = code;
    r.adc  = adc;
    req_feed.push_back(r);
    n_pushed++;
  endtask

  // Sample near a level, now and then at a rail
  function automatic adc_word_t adc_near(int level);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = ADC_MAX;
      default: v = level + int'($urandom_range(0, 128)) - 64;
    endcase
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v[pcef_pkg::ADC_BITS-1:0];
  endfunction

  // Mostly ramp, calibrate, decay, reflect; the rest loose noise
  task automatic add_episode();
    int level_hi;
    int level_lo;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6))
        queue_req(2'($urandom_range(0, 3)), adc_word_t'($urandom_range(0, ADC_MAX)));
    end else begin
      level_hi = $urandom_range(0, ADC_MAX);
      level_lo = $urandom_range(0, ADC_MAX);
      repeat ($urandom_range(1, 24)) queue_req(pcef_pkg::REQ_SAMPLE, adc_near(level_hi));
      queue_req(pcef_pkg::REQ_CALIB, adc_word_t'($urandom_range(0, ADC_MAX)));
      repeat ($urandom_range(0, 24)) queue_req(pcef_pkg::REQ_SAMPLE, adc_near(level_lo));
      queue_req(pcef_pkg::REQ_REFLECT, adc_word_t'($urandom_range(0, ADC_MAX)));
    end
  endtask

  task automatic fill_random(int n_items);
    int target;
    target = n_pushed + n_items;
    while (n_pushed < target) add_episode();
  endtask

  // Wait for every request to go in and every result to come out
  task automatic drain();
    while (!(n_accepted == n_pushed && results_due.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [pcef_pkg::SPV_W-1:0] spv, gain_word_t gain);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pcef_pkg::REG_SAMPLES_PER_VALUE;
    cfg_data  <= {cfg_word_t'($urandom_range(0, 511)) << pcef_pkg::SPV_W} | cfg_word_t'(spv);
    @(posedge clk);
    cfg_index <= pcef_pkg::REG_AMPS_PER_DIGIT;
    cfg_data  <= cfg_word_t'(gain);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Stop the run if it hangs
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d results still due", results_due.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at reset settings: one result per sample
    queue_req(REQ_UNUSED, 12'hFFF);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'h000);
    queue_req(pcef_pkg::REQ_CALIB, 12'hFFF);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'hFFF);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'hFFF);
    queue_req(pcef_pkg::REQ_REFLECT, 12'h000);
    repeat (3) queue_req(pcef_pkg::REQ_SAMPLE, 12'hFFF);
    queue_req(pcef_pkg::REQ_CALIB, 12'h000);
    repeat (2) queue_req(pcef_pkg::REQ_SAMPLE, 12'h000);
    queue_req(pcef_pkg::REQ_REFLECT, 12'hFFF);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'hAAA);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'h555);
    queue_req(REQ_UNUSED, 12'h000);
    queue_req(pcef_pkg::REQ_CALIB, 12'h000);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'hFFF);
    queue_req(pcef_pkg::REQ_SAMPLE, 12'h000);
    drain();

    // Zero count acts as one; full gain; drive a reflection past the top
    write_regs(7'd0, 16'hFFFF);
    repeat (16) queue_req(pcef_pkg::REQ_SAMPLE, 12'hFFF);
    queue_req(pcef_pkg::REQ_CALIB, 12'h000);
    repeat (16) queue_req(pcef_pkg::REQ_SAMPLE, 12'h000);
    queue_req(pcef_pkg::REQ_REFLECT, 12'h000);
    fill_random(20);
    drain();

    // Largest count, zero gain
    write_regs(7'(MAX_SAMPLES), 16'h0000);
    fill_random(70);
    drain();

    // Small count with a long output hold-off to back up the input
    write_regs(7'd3, gain_word_t'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    fill_random(110);
    drain();

    // Unit count, smallest non-zero gain
    write_regs(7'd1, 16'd1);
    fill_random(60);
    drain();

    // Count above the limit saturates
    write_regs(7'd127, gain_word_t'($urandom_range(0, 65535)));
    fill_random(70);
    drain();

    write_regs(7'($urandom_range(1, 8)), gain_word_t'($urandom_range(0, 65535)));
    fill_random(70);
    drain();

    $display("Run covered %0d requests (%0d calibrations, %0d reflections, %0d unused codes)",
             n_accepted, n_calib, n_reflect, n_ignored);
    $display("and %0d result beats over %0d register settings;", n_checked, n_settings);
    $display("reflections clamped high %0d, to zero %0d", n_clamp_top, n_clamp_zero);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pcef_pkg.sv
sv/pcef_front.sv
sv/pcef_queue.sv
sv/pcef_back.sv
sv/pcef_result.sv
sv/phase_current_ema_filter_unit.sv
sv/pcef_checker.sv
tb/tb.sv
